/* hw/rtl/vrq_pkg.sv */
`timescale 1ns / 1ps

package vrq_pkg;

  localparam int UID_BYTES = 8;
  localparam int UID_W = 8 * UID_BYTES;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_UID = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_AFI = 1'b1;

  localparam logic [7:0] CMD_INVENTORY = 8'h01;
  localparam logic [7:0] CUSTOM_FIRST = 8'hA0;
  localparam logic [7:0] MASK_LIMIT = 8'(8 * UID_BYTES);
  localparam logic [7:0] INDEX_MAX = 8'hFF;

  localparam int FLAG_INVENTORY_BIT = 2;
  localparam int FLAG_SELECT_BIT = 4;
  localparam int FLAG_AFI_BIT = 4;
  localparam int FLAG_ADDRESS_BIT = 5;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [3:0] PARAM_BASE = 4'd2;

  localparam logic [2:0] REJ_NONE = 3'd0;
  localparam logic [2:0] REJ_AFI = 3'd1;
  localparam logic [2:0] REJ_MFG = 3'd2;
  localparam logic [2:0] REJ_UID = 3'd3;
  localparam logic [2:0] REJ_NOT_SELECTED = 3'd4;
  localparam logic [2:0] REJ_TOO_SHORT = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       sel;
  } vrq_word_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] reject_reason;
    logic       crc_ok;
    logic [7:0] command_code;
    logic [7:0] request_flags;
    logic       is_addressed;
    logic       is_select_mode;
    logic [7:0] param_offset;
    logic [7:0] param_length;
    logic       mask_match;
  } vrq_result_t;

endpackage

/* hw/rtl/vrq_crc16.sv */
`timescale 1ns / 1ps

// Reflected CRC-16, one byte per call, LSB first.
module vrq_crc16 (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);

  always_comb begin
    logic [15:0] r;
    r = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ vrq_pkg::CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    crc_next = r;
  end

endmodule

/* hw/rtl/vrq_frame.sv */
`timescale 1ns / 1ps

// Frame state. Each body byte is checked two words after it arrives, so the
// last two words of a frame stay in the tail and hold the received CRC.
module vrq_frame (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  vrq_pkg::vrq_word_t        word,
  input  logic [vrq_pkg::UID_W-1:0] own_uid,
  input  logic [7:0]                own_afi,
  output vrq_pkg::vrq_result_t      result
);

  logic [7:0]  byte_index;
  logic [7:0]  flags_seen;
  logic [7:0]  command_seen;
  logic [15:0] crc_register;
  logic [15:0] tail_bytes;
  logic [3:0]  param_start;
  logic [2:0]  reject_code;
  logic [6:0]  mask_bits;
  logic        mask_failed;

  logic [7:0]  byte_index_next;
  logic [7:0]  flags_seen_next;
  logic [7:0]  command_seen_next;
  logic [15:0] crc_register_next;
  logic [15:0] tail_bytes_next;
  logic [3:0]  param_start_next;
  logic [2:0]  reject_code_next;
  logic [6:0]  mask_bits_next;
  logic        mask_failed_next;

  logic [15:0] crc_fed;
  logic [7:0]  old;

  function automatic logic has_extra(input logic [7:0] f, input logic [7:0] c);
    return (c >= vrq_pkg::CUSTOM_FIRST) ||
           (c == vrq_pkg::CMD_INVENTORY && f[vrq_pkg::FLAG_AFI_BIT]);
  endfunction

  function automatic logic addressed(input logic [7:0] f);
    return !f[vrq_pkg::FLAG_INVENTORY_BIT] && f[vrq_pkg::FLAG_ADDRESS_BIT];
  endfunction

  function automatic logic select_mode(input logic [7:0] f);
    return !f[vrq_pkg::FLAG_INVENTORY_BIT] && f[vrq_pkg::FLAG_SELECT_BIT];
  endfunction

  function automatic logic [2:0] extra_code(input logic [7:0] c);
    return (c >= vrq_pkg::CUSTOM_FIRST) ? vrq_pkg::REJ_MFG : vrq_pkg::REJ_AFI;
  endfunction

  function automatic logic [7:0] uid_byte(input logic [vrq_pkg::UID_W-1:0] uid,
                                          input logic [2:0] k);
    return uid[{k, 3'b000} +: 8];
  endfunction

  assign old = tail_bytes[7:0];

  vrq_crc16 u_crc (
    .crc      (crc_register),
    .data     (old),
    .crc_next (crc_fed)
  );

  // Apply the oldest tail byte as body byte p.
  always_comb begin
    logic [7:0] p;
    logic       extra;
    logic [7:0] ustart;
    logic [7:0] want;
    logic [7:0] m;
    logic [3:0] full;
    logic [2:0] rem;
    logic [7:0] bm;
    logic [7:0] ps_ext;

    flags_seen_next   = flags_seen;
    command_seen_next = command_seen;
    crc_register_next = crc_register;
    param_start_next  = param_start;
    reject_code_next  = reject_code;
    mask_bits_next    = mask_bits;
    mask_failed_next  = mask_failed;

    p      = byte_index - 8'd2;
    extra  = has_extra(flags_seen, command_seen);
    ustart = 8'd2 + {7'd0, extra};
    want   = (command_seen >= vrq_pkg::CUSTOM_FIRST) ?
             uid_byte(own_uid, 3'(vrq_pkg::UID_BYTES - 2)) : own_afi;
    ps_ext = {4'd0, param_start};
    m      = p - ps_ext - 8'd1;
    full   = mask_bits[6:3];
    rem    = mask_bits[2:0];
    bm     = (8'd1 << rem) - 8'd1;

    if (byte_index >= 8'd2) begin
      crc_register_next = crc_fed;
      if (p == 8'd0) begin
        flags_seen_next = old;
      end else if (p == 8'd1) begin
        command_seen_next = old;
        param_start_next  = vrq_pkg::PARAM_BASE + {3'd0, has_extra(flags_seen, old)} +
                            (addressed(flags_seen) ? 4'(vrq_pkg::UID_BYTES) : 4'd0);
      end else begin
        if (extra && p == 8'd2 && old != want && reject_code_next == vrq_pkg::REJ_NONE) begin
          reject_code_next = extra_code(command_seen);
        end
        if (addressed(flags_seen) && p >= ustart &&
            p < ustart + 8'(vrq_pkg::UID_BYTES)) begin
          if (old != uid_byte(own_uid, 3'(p - ustart)) &&
              reject_code_next == vrq_pkg::REJ_NONE) begin
            reject_code_next = vrq_pkg::REJ_UID;
          end
        end
        if (p == ps_ext) begin
          if (old > vrq_pkg::MASK_LIMIT) begin
            mask_bits_next   = 7'h7F;
            mask_failed_next = 1'b1;
          end else begin
            mask_bits_next = old[6:0];
          end
        end else if (p > ps_ext && !mask_failed && m[7:3] == 5'd0) begin
          if (m < {4'd0, full}) begin
            if (old != uid_byte(own_uid, m[2:0])) begin
              mask_failed_next = 1'b1;
            end
          end else if (m == {4'd0, full} && rem != 3'd0) begin
            if ((old & bm) != (uid_byte(own_uid, m[2:0]) & bm)) begin
              mask_failed_next = 1'b1;
            end
          end
        end
      end
    end

    tail_bytes_next = {word.data, tail_bytes[15:8]};
    byte_index_next = (byte_index == vrq_pkg::INDEX_MAX) ? byte_index : byte_index + 8'd1;
  end

  // Verdict for the frame that ends with this word.
  always_comb begin
    logic [7:0] body;
    logic       too_short;
    logic [2:0] code;
    logic [7:0] ps_ext;
    logic [7:0] needed;
    logic [8:0] need_end;
    logic       addr;

    body      = (byte_index_next >= 8'd2) ? byte_index_next - 8'd2 : 8'd0;
    too_short = byte_index_next < 8'd4;
    ps_ext    = {4'd0, param_start_next};
    needed    = ({1'b0, mask_bits_next} + 8'd7) >> 3;
    need_end  = {1'b0, ps_ext} + 9'd1 + {1'b0, needed};
    addr      = addressed(flags_seen_next);
    code      = reject_code_next;

    result = '0;
    if (too_short) begin
      code = vrq_pkg::REJ_TOO_SHORT;
    end else begin
      if (code == vrq_pkg::REJ_NONE && body < ps_ext) begin
        if (has_extra(flags_seen_next, command_seen_next) && body <= 8'd2) begin
          code = extra_code(command_seen_next);
        end else if (addr) begin
          code = vrq_pkg::REJ_UID;
        end
      end
      if (code == vrq_pkg::REJ_NONE && select_mode(flags_seen_next) && !word.sel) begin
        code = vrq_pkg::REJ_NOT_SELECTED;
      end
      if (body > ps_ext) begin
        result.param_length = body - ps_ext;
      end
      result.mask_match = command_seen_next == vrq_pkg::CMD_INVENTORY &&
                          !mask_failed_next && body > ps_ext &&
                          {1'b0, body} >= need_end;
      result.crc_ok = ~crc_register_next == tail_bytes_next;
    end

    result.accept         = code == vrq_pkg::REJ_NONE;
    result.reject_reason  = code;
    result.command_code   = command_seen_next;
    result.request_flags  = flags_seen_next;
    result.is_addressed   = addr;
    result.is_select_mode = select_mode(flags_seen_next);
    result.param_offset   = ps_ext;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && word.last)) begin
      byte_index   <= 8'd0;
      flags_seen   <= 8'd0;
      command_seen <= 8'd0;
      crc_register <= vrq_pkg::CRC_PRESET;
      tail_bytes   <= 16'd0;
      param_start  <= vrq_pkg::PARAM_BASE;
      reject_code  <= vrq_pkg::REJ_NONE;
      mask_bits    <= 7'd0;
      mask_failed  <= 1'b0;
    end else if (step) begin
      byte_index   <= byte_index_next;
      flags_seen   <= flags_seen_next;
      command_seen <= command_seen_next;
      crc_register <= crc_register_next;
      tail_bytes   <= tail_bytes_next;
      param_start  <= param_start_next;
      reject_code  <= reject_code_next;
      mask_bits    <= mask_bits_next;
      mask_failed  <= mask_failed_next;
    end
  end

endmodule

/* hw/rtl/vicinity_request_qualifier_core.sv */
`timescale 1ns / 1ps

// Path: a word is registered at the input and checked from that register; a
// last word's verdict then goes into the output register, once that is free.
// Throughput: one word per cycle; the output register frees the input side
// while a verdict waits, and only a last word waits for a full output.
// Reset (rst, synchronous): clears frame state to its start values and own_uid and own_afi to zero.
module vicinity_request_qualifier_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  input  logic                            tag_selected,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            accept,
  output logic [2:0]                      reject_reason,
  output logic                            crc_ok,
  output logic [7:0]                      command_code,
  output logic [7:0]                      request_flags,
  output logic                            is_addressed,
  output logic                            is_select_mode,
  output logic [7:0]                      param_offset,
  output logic [7:0]                      param_length,
  output logic                            mask_match,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vrq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vrq_pkg::UID_W-1:0]       cfg_data
);

  logic [vrq_pkg::UID_W-1:0] own_uid;
  logic [7:0]                own_afi;

  logic                 in_full;
  vrq_pkg::vrq_word_t   in_word;
  logic                 in_take;
  logic                 advance;
  vrq_pkg::vrq_result_t verdict;
  vrq_pkg::vrq_result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_uid <= '0;
      own_afi <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vrq_pkg::CFG_OWN_UID: own_uid <= cfg_data;
        vrq_pkg::CFG_OWN_AFI: own_afi <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A word that ends a frame moves on only when the output register is free.
  assign advance  = in_full && (!in_word.last || !out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word <= '{data: data_byte, last: last_byte, sel: tag_selected};
    end
  end

  vrq_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .word    (in_word),
    .own_uid (own_uid),
    .own_afi (own_afi),
    .result  (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_word.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_word.last) begin
      result <= verdict;
    end
  end

  assign accept         = result.accept;
  assign reject_reason  = result.reject_reason;
  assign crc_ok         = result.crc_ok;
  assign command_code   = result.command_code;
  assign request_flags  = result.request_flags;
  assign is_addressed   = result.is_addressed;
  assign is_select_mode = result.is_select_mode;
  assign param_offset   = result.param_offset;
  assign param_length   = result.param_length;
  assign mask_match     = result.mask_match;

endmodule

/* hw/rtl/vrq_checker.sv */
`timescale 1ns / 1ps

module vrq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       accept,
  input logic [2:0] reject_reason,
  input logic       crc_ok,
  input logic [7:0] command_code,
  input logic [7:0] request_flags,
  input logic       is_addressed,
  input logic [7:0] param_length,
  input logic       mask_match
);

  // A held verdict does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reject_reason) &&
      $stable(command_code) && $stable(param_length))
    else $error("verdict changed while stalled");

  // With the output register empty, the input never stalls.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> accept == (reject_reason == vrq_pkg::REJ_NONE))
    else $error("accept disagrees with reject reason");

  a_short_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && reject_reason == vrq_pkg::REJ_TOO_SHORT |->
      !crc_ok && param_length == 8'd0 && !mask_match)
    else $error("short frame reports checks");

  a_addressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_addressed ==
      (request_flags[vrq_pkg::FLAG_ADDRESS_BIT] && !request_flags[vrq_pkg::FLAG_INVENTORY_BIT]))
    else $error("addressed flag decode wrong");

endmodule

bind vicinity_request_qualifier_core vrq_checker u_vrq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .accept        (accept),
  .reject_reason (reject_reason),
  .crc_ok        (crc_ok),
  .command_code  (command_code),
  .request_flags (request_flags),
  .is_addressed  (is_addressed),
  .param_length  (param_length),
  .mask_match    (mask_match)
);
